>>> design/spa_pkg.sv
// shared types and constants for the sparse polynomial adder
package spa_pkg;

  localparam int TermDepthDefault = 16;
  localparam int CoefW = 16;
  localparam int ExpW  = 8;
  localparam int SumW  = 17;
  localparam int ModeW = 2;

  localparam logic [ModeW-1:0] ModeLoadA = 2'd0;
  localparam logic [ModeW-1:0] ModeLoadB = 2'd1;
  localparam logic [ModeW-1:0] ModeStart = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [CoefW-1:0] coefficient;
    logic [ExpW-1:0]         exponent;
  } spa_req_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum_coefficient;
    logic [ExpW-1:0]        sum_exponent;
    logic                   last;
    logic                   terms_dropped;
  } spa_res_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic merge_step;
    logic emit_init;
    logic emit_step;
    logic clear;
  } spa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic merge_done;
    logic emit_empty;
  } spa_status_t;

endpackage

>>> design/spa_ram.sv
// generic single write port ram with registered read
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> design/spa_ctrl.sv
// controller state machine: load decode, merge walk, reversed emit
module spa_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [spa_pkg::ModeW-1:0]  mode_i,
  input  spa_pkg::spa_status_t       status_i,
  output spa_pkg::spa_cmd_t          cmd_o,
  output logic                       busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_a = accept && (mode_i == spa_pkg::ModeLoadA);
        cmd_o.load_b = accept && (mode_i == spa_pkg::ModeLoadB);
        cmd_o.start  = accept && (mode_i == spa_pkg::ModeStart);
      end
      ST_MERGE: begin
        cmd_o.merge_step = !status_i.merge_done;
        cmd_o.emit_init  = status_i.merge_done;
      end
      ST_EMIT: begin
        cmd_o.emit_step = !status_i.emit_empty;
      end
      ST_DONE: begin
        cmd_o.clear = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (mode_i == spa_pkg::ModeStart)) begin
            state_q <= ST_MERGE;
            busy_q  <= 1'b1;
          end
        end
        ST_MERGE: begin
          if (status_i.merge_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // the final read's data is on the ports while k is already zero
          if (status_i.emit_empty) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> design/spa_datapath.sv
// term stores, merge compare and add, run buffer and result register
module spa_datapath #(
  parameter int TERM_DEPTH = spa_pkg::TermDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spa_pkg::spa_req_t req_i,
  input  spa_pkg::spa_cmd_t cmd_i,
  output spa_pkg::spa_status_t status_o,
  output spa_pkg::spa_res_t res_o,
  output logic              res_valid_o
);

  localparam int CntW     = $clog2(TERM_DEPTH + 1);
  localparam int IdxW     = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
  localparam int RunDepth = 2 * TERM_DEPTH;
  localparam int RunIdxW  = $clog2(RunDepth);
  localparam int RunCntW  = $clog2(RunDepth + 1);
  localparam int RunW     = spa_pkg::SumW + spa_pkg::ExpW;

  logic [spa_pkg::CoefW-1:0] a_coef_q [TERM_DEPTH];
  logic [spa_pkg::ExpW-1:0]  a_exp_q  [TERM_DEPTH];
  logic [spa_pkg::CoefW-1:0] b_coef_q [TERM_DEPTH];
  logic [spa_pkg::ExpW-1:0]  b_exp_q  [TERM_DEPTH];

  logic [CntW-1:0]    a_cnt_q, b_cnt_q;
  logic [CntW-1:0]    i_q, j_q;
  logic [RunCntW-1:0] n_q, k_q;
  logic               flag_q;
  logic               valid_q, last_q;

  logic [CntW-1:0]    i_m1, j_m1;
  logic [IdxW-1:0]    ia, jb;
  logic [RunCntW-1:0] k_m1;
  logic               a_full, b_full;

  logic signed [spa_pkg::SumW-1:0] ca, cb, run_coef;
  logic [spa_pkg::ExpW-1:0]        ea, eb, run_exp;
  logic                            take_a, take_b;
  logic [RunW-1:0]                 rdata;

  assign a_full = (a_cnt_q == CntW'(TERM_DEPTH));
  assign b_full = (b_cnt_q == CntW'(TERM_DEPTH));

  assign i_m1 = i_q - CntW'(1);
  assign j_m1 = j_q - CntW'(1);
  assign ia   = i_m1[IdxW-1:0];
  assign jb   = j_m1[IdxW-1:0];
  assign k_m1 = k_q - RunCntW'(1);

  assign ca = spa_pkg::SumW'($signed(a_coef_q[ia]));
  assign cb = spa_pkg::SumW'($signed(b_coef_q[jb]));
  assign ea = a_exp_q[ia];
  assign eb = b_exp_q[jb];

  // walk from the newest term, smaller exponent first, both on a tie
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    priority if ((i_q != '0) && (j_q != '0)) begin
      take_a = (ea <= eb);
      take_b = (eb <= ea);
    end else if (i_q != '0) begin
      take_a = 1'b1;
    end else begin
      take_b = (j_q != '0);
    end
  end

  always_comb begin
    run_coef = '0;
    run_exp  = ea;
    if (take_a) begin
      run_coef = ca;
    end
    if (take_b) begin
      run_coef = run_coef + cb;
      run_exp  = eb;
    end
  end

  assign status_o.merge_done = (i_q == '0) && (j_q == '0);
  assign status_o.emit_empty = (k_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !a_full) begin
      a_coef_q[a_cnt_q[IdxW-1:0]] <= req_i.coefficient;
      a_exp_q[a_cnt_q[IdxW-1:0]]  <= req_i.exponent;
    end
    if (cmd_i.load_b && !b_full) begin
      b_coef_q[b_cnt_q[IdxW-1:0]] <= req_i.coefficient;
      b_exp_q[b_cnt_q[IdxW-1:0]]  <= req_i.exponent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      flag_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.load_a) begin
        if (a_full) begin
          flag_q <= 1'b1;
        end else begin
          a_cnt_q <= a_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.load_b) begin
        if (b_full) begin
          flag_q <= 1'b1;
        end else begin
          b_cnt_q <= b_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.start) begin
        i_q <= a_cnt_q;
        j_q <= b_cnt_q;
        n_q <= '0;
      end
      if (cmd_i.merge_step) begin
        if (take_a) begin
          i_q <= i_m1;
        end
        if (take_b) begin
          j_q <= j_m1;
        end
        n_q <= n_q + RunCntW'(1);
      end
      if (cmd_i.emit_init) begin
        k_q <= n_q;
      end
      if (cmd_i.emit_step) begin
        k_q <= k_m1;
      end
      valid_q <= cmd_i.emit_step;
      last_q  <= cmd_i.emit_step && (k_q == RunCntW'(1));
      if (cmd_i.clear) begin
        a_cnt_q <= '0;
        b_cnt_q <= '0;
        flag_q  <= 1'b0;
      end
    end
  end

  // run buffer: written in walk order, read back newest first
  spa_ram #(
    .WIDTH(RunW),
    .DEPTH(RunDepth)
  ) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.merge_step),
    .waddr_i(n_q[RunIdxW-1:0]),
    .wdata_i({run_coef, run_exp}),
    .re_i   (cmd_i.emit_step),
    .raddr_i(k_m1[RunIdxW-1:0]),
    .rdata_o(rdata)
  );

  assign res_o.sum_coefficient = rdata[RunW-1:spa_pkg::ExpW];
  assign res_o.sum_exponent    = rdata[spa_pkg::ExpW-1:0];
  assign res_o.last            = last_q;
  assign res_o.terms_dropped   = flag_q;
  assign res_valid_o           = valid_q;

endmodule

>>> design/sparse_polynomial_adder_top.sv
// top level of the sparse polynomial adder: controller, datapath, checks
//
//   channel   direction  handshake                    payload
//   request   in         start & !busy                req_i   (spa_req_t)
//   result    out        res_valid_o, one cycle only  res_o   (spa_res_t)
//
// a load request leaves busy low
// a start request holds busy while it walks both lists into the run buffer,
// writing one result term per step, then reads the terms back through the
// ram's registered port, plus turnaround and clear
// reset clears both term counts and the dropped flag; term stores need no reset
// results go out back to back and the receiver takes every strobe
module sparse_polynomial_adder_top #(
  parameter int TERM_DEPTH = spa_pkg::TermDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  spa_pkg::spa_req_t req_i,
  output spa_pkg::spa_res_t res_o,
  output logic              res_valid_o
);

  spa_pkg::spa_cmd_t    cmd;
  spa_pkg::spa_status_t status;

  spa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (req_i.mode),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  spa_datapath #(
    .TERM_DEPTH(TERM_DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe outside a start request");

  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.mode == spa_pkg::ModeStart)) |=> busy)
    else $error("start request did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.mode != spa_pkg::ModeStart)) |=> !busy)
    else $error("load request raised busy");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> !res_valid_o)
    else $error("result after last term");

endmodule
